@@ design/lbspi_pkg.sv @@
// Package for the LED bit to SPI pattern encoder.
// Types, register indexes, reset values and the code width helper.
// No dependencies.
package lbspi_pkg;

  localparam int SPI_W    = 8;
  localparam int CODE_W   = 4;
  localparam int GAP_W    = 7;
  localparam int STREAM_W = 64;
  localparam int CNT_W    = 7;
  localparam int IDX_W    = 2;

  localparam int FIFO_DEPTH_DEF = 2;

  localparam logic [GAP_W-1:0]  GAP_CAP  = 7'd64;
  localparam logic [CODE_W-1:0] CODE_MAX = 4'd8;

  localparam logic [IDX_W-1:0] REG_BITS_PER_CODE = 2'd0;
  localparam logic [IDX_W-1:0] REG_PATTERN_ONE   = 2'd1;
  localparam logic [IDX_W-1:0] REG_PATTERN_ZERO  = 2'd2;
  localparam logic [IDX_W-1:0] REG_GAP_BYTES     = 2'd3;

  localparam logic [CODE_W-1:0] RST_BITS_PER_CODE = 4'd4;
  localparam logic [SPI_W-1:0]  RST_PATTERN_ONE   = 8'h0E;
  localparam logic [SPI_W-1:0]  RST_PATTERN_ZERO  = 8'h08;
  localparam logic [GAP_W-1:0]  RST_GAP_BYTES     = 7'd20;

  localparam logic ACT_GAP  = 1'b0;
  localparam logic ACT_DATA = 1'b1;

  typedef struct packed {
    logic [CODE_W-1:0] bits_per_code;
    logic [SPI_W-1:0]  pattern_one;
    logic [SPI_W-1:0]  pattern_zero;
    logic [GAP_W-1:0]  gap_bytes;
  } lbspi_cfg_t;

  typedef struct packed {
    logic [STREAM_W-1:0] stream;
    logic [CNT_W-1:0]    count;
  } lbspi_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } lbspi_fifo_stat_t;

  function automatic logic [CODE_W-1:0] code_width(input logic [CODE_W-1:0] n);
    logic [CODE_W-1:0] w;
    if (n == '0) begin
      w = 4'd1;
    end else if (n > CODE_MAX) begin
      w = CODE_MAX;
    end else begin
      w = n;
    end
    return w;
  endfunction

endpackage

@@ design/lbspi_front.sv @@
// Front end: accepts input transactions and expands them into SPI jobs.
// Builds the left-aligned bit stream or the gap length. Uses lbspi_pkg.
module lbspi_front (
  input  lbspi_pkg::lbspi_cfg_t       cfg,
  input  logic                        in_valid,
  input  logic                        in_action,
  input  logic [7:0]                  in_color_byte,
  input  lbspi_pkg::lbspi_fifo_stat_t fifo_stat,
  output logic                        in_ready,
  output logic                        push,
  output lbspi_pkg::lbspi_job_t       job
);
  import lbspi_pkg::*;

  logic [CODE_W-1:0]   n;
  logic [CODE_W-1:0]   pad;
  logic [SPI_W-1:0]    top_one;
  logic [SPI_W-1:0]    top_zero;
  logic [STREAM_W-1:0] stream;
  logic [GAP_W-1:0]    gap_cnt;

  always_comb begin
    n        = code_width(cfg.bits_per_code);
    pad      = CODE_MAX - n;
    top_one  = SPI_W'(cfg.pattern_one << pad);
    top_zero = SPI_W'(cfg.pattern_zero << pad);
    stream   = '0;
    for (int b = 0; b < 8; b++) begin
      stream = stream | ({(in_color_byte[7-b] ? top_one : top_zero),
                          {(STREAM_W-SPI_W){1'b0}}}
                         >> (6'(b) * {2'b00, n}));
    end
    gap_cnt = (cfg.gap_bytes > GAP_CAP) ? GAP_CAP : cfg.gap_bytes;
  end

  assign in_ready = !fifo_stat.full;
  assign push     = in_valid && !fifo_stat.full &&
                    !(in_action == ACT_GAP && gap_cnt == '0);

  always_comb begin
    if (in_action == ACT_DATA) begin
      job.stream = stream;
      job.count  = {3'b000, n};
    end else begin
      job.stream = '0;
      job.count  = gap_cnt;
    end
  end

endmodule

@@ design/lbspi_fifo.sv @@
// Short job queue between front end and byte emitter.
// Register array with read and write pointers. Uses lbspi_pkg.
module lbspi_fifo #(
  parameter int DEPTH = lbspi_pkg::FIFO_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  lbspi_pkg::lbspi_job_t       wr_job,
  input  logic                        pop,
  output lbspi_pkg::lbspi_job_t       rd_job,
  output lbspi_pkg::lbspi_fifo_stat_t stat
);
  import lbspi_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  lbspi_job_t      mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

  assign rd_job     = mem_r[rd_ptr_r];
  assign stat.full  = (cnt_r == FULL_CNT);
  assign stat.empty = (cnt_r == '0);

endmodule

@@ design/lbspi_back.sv @@
// Back end: emits one SPI byte per cycle from the current job while out_ready is high.
// Holds the output register and the remaining byte count. Uses lbspi_pkg.
module lbspi_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lbspi_pkg::lbspi_job_t       job,
  input  lbspi_pkg::lbspi_fifo_stat_t fifo_stat,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  out_spi_data,
  output logic                        out_last_of_run
);
  import lbspi_pkg::*;

  logic [STREAM_W-1:0] stream_r, stream_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                valid_r, valid_nxt;
  logic                last;
  logic                done;
  logic                step;

  assign last = (cnt_r == 7'd1);
  assign done = valid_r && out_ready && last;
  assign step = valid_r && out_ready && !last;
  assign pop  = (!valid_r || done) && !fifo_stat.empty;

  always_comb begin
    stream_nxt = stream_r;
    cnt_nxt    = cnt_r;
    valid_nxt  = valid_r;
    if (pop) begin
      stream_nxt = job.stream;
      cnt_nxt    = job.count;
      valid_nxt  = 1'b1;
    end else if (done) begin
      cnt_nxt    = '0;
      valid_nxt  = 1'b0;
    end else if (step) begin
      stream_nxt = {stream_r[STREAM_W-SPI_W-1:0], {SPI_W{1'b0}}};
      cnt_nxt    = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stream_r <= stream_nxt;
  end

  assign out_valid       = valid_r;
  assign out_spi_data    = stream_r[STREAM_W-1 -: SPI_W];
  assign out_last_of_run = last;

endmodule

@@ design/led_bit_to_spi_pattern_encoder.sv @@
// LED bit to SPI pattern encoder, top level.
// Holds the configuration registers; instantiates lbspi_front, lbspi_fifo
// and lbspi_back. Uses lbspi_pkg.
//
// Usage: each input transaction is either a frame start (in_action 0), which
// produces min(gap_bytes, 64) zero bytes, or a data byte (in_action 1), which
// produces N bytes, N = bits_per_code clamped to 1..8. Each LED bit maps to
// the low N bits of pattern_one or pattern_zero, MSB first.
// Output transactions carry one SPI byte; out_last_of_run marks the final
// byte of each input transaction. A frame start with gap 0 produces nothing.
// The first byte of an item passes through the job queue and then the
// emitter register before it appears. Throughput: one output byte per cycle
// from the emitter register while out_ready is high; consecutive items follow
// without bubbles when the next job is already queued.
// The job queue (FIFO_DEPTH entries) lets input be accepted while the
// emitter works or the receiver stalls; in_ready drops only when it is full.
// Configuration writes are always accepted (cfg_ready high); write only
// while idle. Reset empties the queue and loads the default registers.
module led_bit_to_spi_pattern_encoder #(
  parameter int FIFO_DEPTH = lbspi_pkg::FIFO_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_action,
  input  logic [7:0] in_color_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_spi_data,
  output logic       out_last_of_run
);
  import lbspi_pkg::*;

  lbspi_cfg_t       cfg_r, cfg_nxt;
  lbspi_job_t       wr_job;
  lbspi_job_t       rd_job;
  lbspi_fifo_stat_t fifo_stat;
  logic             push;
  logic             pop;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_BITS_PER_CODE: cfg_nxt.bits_per_code = cfg_data[CODE_W-1:0];
        REG_PATTERN_ONE:   cfg_nxt.pattern_one   = cfg_data;
        REG_PATTERN_ZERO:  cfg_nxt.pattern_zero  = cfg_data;
        REG_GAP_BYTES:     cfg_nxt.gap_bytes     = cfg_data[GAP_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bits_per_code <= RST_BITS_PER_CODE;
      cfg_r.pattern_one   <= RST_PATTERN_ONE;
      cfg_r.pattern_zero  <= RST_PATTERN_ZERO;
      cfg_r.gap_bytes     <= RST_GAP_BYTES;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  lbspi_front u_front (
    .cfg           (cfg_r),
    .in_valid      (in_valid),
    .in_action     (in_action),
    .in_color_byte (in_color_byte),
    .fifo_stat     (fifo_stat),
    .in_ready      (in_ready),
    .push          (push),
    .job           (wr_job)
  );

  lbspi_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_job (wr_job),
    .pop    (pop),
    .rd_job (rd_job),
    .stat   (fifo_stat)
  );

  lbspi_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .job             (rd_job),
    .fifo_stat       (fifo_stat),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_spi_data    (out_spi_data),
    .out_last_of_run (out_last_of_run)
  );

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !fifo_stat.full)
    else $error("queue written while full");

  a_data_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_action == ACT_DATA) |-> push)
    else $error("data transaction accepted but not queued");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last_of_run) |=> out_valid)
    else $error("run ended before its last byte");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !fifo_stat.empty)
    else $error("queue read while empty");
`endif

endmodule

@@ tb/sv/led_bit_to_spi_pattern_encoder_tb.sv @@
// Self-checking testbench for led_bit_to_spi_pattern_encoder: directed and random
// frame-start and data transactions under several register settings, with random stalls.
// Depends on lbspi_pkg and the encoder RTL.
module led_bit_to_spi_pattern_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lbspi_pkg::*;

  typedef struct {
    logic       act;
    logic [7:0] color;
    bit         hold;
  } led_item_t;

  typedef struct {
    logic [7:0] spi;
    logic       last_flag;
  } spi_exp_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = REG_BITS_PER_CODE;
  logic [7:0] cfg_data = 8'h00;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       in_action = ACT_GAP;
  logic [7:0] in_color_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_spi_data;
  logic       out_last_of_run;

  // register mirror
  logic [3:0] bpc_reg;
  logic [7:0] one_reg;
  logic [7:0] zero_reg;
  logic [6:0] gap_reg;

  led_item_t led_item_q[$];
  spi_exp_t  spi_exp_q[$];
  int        err_cnt = 0;
  int        cfg_acc_cnt = 0;
  int        in_acc_cnt = 0;
  int        in_launch_cnt = 0;
  int        out_acc_cnt = 0;
  int        out_seen = 0;
  int        in_wait = 0;
  int        out_stall = 0;
  bit        in_burst = 1'b0;
  bit        out_burst = 1'b0;

  led_bit_to_spi_pattern_encoder dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_color_byte  (in_color_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_spi_data   (out_spi_data),
    .out_last_of_run(out_last_of_run)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    if (err_cnt < 100) begin
      $display("%0t ns: mismatch: %s", $time, msg);
    end
    err_cnt++;
  endtask

  // expected SPI bytes for one accepted transaction
  task automatic encode_led_item(input logic act, input logic [7:0] color);
    int         cnt;
    int         width;
    logic [7:0] msk;
    logic [7:0] pat;
    logic [63:0] stream;
    spi_exp_t   e;
    if (act == ACT_GAP) begin
      cnt = (gap_reg > GAP_CAP) ? int'(GAP_CAP) : int'(gap_reg);
      for (int k = 0; k < cnt; k++) begin
        e.spi = 8'h00;
        e.last_flag = (k == cnt - 1);
        spi_exp_q.push_back(e);
      end
    end else begin
      width = (bpc_reg == 4'd0) ? 1 : (bpc_reg > 4'd8) ? 8 : int'(bpc_reg);
      msk = 8'((16'd1 << width) - 16'd1);
      stream = '0;
      for (int b = 7; b >= 0; b--) begin
        pat = color[b] ? one_reg : zero_reg;
        stream = (stream << width) | 64'(pat & msk);
      end
      for (int k = 0; k < width; k++) begin
        e.spi = 8'(stream >> (8 * (width - 1 - k)));
        e.last_flag = (k == width - 1);
        spi_exp_q.push_back(e);
      end
    end
  endtask

  // monitor: register writes, accepted inputs, output checks
  always @(posedge clk) begin
    spi_exp_t e;
    if (!rst_n) begin
      bpc_reg  <= RST_BITS_PER_CODE;
      one_reg  <= RST_PATTERN_ONE;
      zero_reg <= RST_PATTERN_ZERO;
      gap_reg  <= RST_GAP_BYTES;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BITS_PER_CODE: bpc_reg  <= cfg_data[3:0];
          REG_PATTERN_ONE:   one_reg  <= cfg_data;
          REG_PATTERN_ZERO:  zero_reg <= cfg_data;
          REG_GAP_BYTES:     gap_reg  <= cfg_data[6:0];
          default: ;
        endcase
        cfg_acc_cnt <= cfg_acc_cnt + 1;
      end
      if (out_valid && out_ready) begin
        out_acc_cnt <= out_acc_cnt + 1;
        if (spi_exp_q.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h last %0b", out_spi_data,
                                    out_last_of_run));
        end else begin
          e = spi_exp_q.pop_front();
          if (out_spi_data !== e.spi) begin
            report_mismatch($sformatf("spi_data %02h, expected %02h", out_spi_data, e.spi));
          end
          if (out_last_of_run !== e.last_flag) begin
            report_mismatch($sformatf("last_of_run %0b, expected %0b", out_last_of_run,
                                      e.last_flag));
          end
        end
      end
      if (in_valid && in_ready) begin
        in_acc_cnt <= in_acc_cnt + 1;
        encode_led_item(in_action, in_color_byte);
      end
    end
  end

  // input driver
  always @(negedge clk) begin
    led_item_t it;
    logic      nxt_valid;
    nxt_valid = in_valid;
    if (!rst_n) begin
      nxt_valid = 1'b0;
    end else if (!(in_valid && in_acc_cnt != in_launch_cnt)) begin
      nxt_valid = 1'b0;
      if (in_wait > 0) begin
        in_wait = in_wait - 1;
      end else if (led_item_q.size() != 0 &&
                   !(led_item_q[0].hold && spi_exp_q.size() != 0)) begin
        it = led_item_q.pop_front();
        nxt_valid = 1'b1;
        in_action <= it.act;
        in_color_byte <= it.color;
        in_launch_cnt = in_launch_cnt + 1;
        in_wait = in_burst ? 0 : $urandom_range(0, 8);
      end
    end
    in_valid <= nxt_valid;
  end

  // result backpressure
  always @(negedge clk) begin
    if (out_acc_cnt != out_seen) begin
      out_seen = out_acc_cnt;
      out_stall = out_burst ? 0 : $urandom_range(0, 8);
    end
    if (out_stall > 0) begin
      out_stall = out_stall - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic queue_item(input logic act, input logic [7:0] color, input bit hold);
    led_item_t it;
    it.act = act;
    it.color = color;
    it.hold = hold;
    led_item_q.push_back(it);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
    int target;
    @(negedge clk);
    target = cfg_acc_cnt + 1;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do begin
      @(negedge clk);
    end while (cfg_acc_cnt != target);
    cfg_valid <= 1'b0;
  endtask

  // wait until all transactions are in and all bytes are out, then let a gap
  // item with no output finish
  task automatic wait_drained();
    @(negedge clk);
    while (!(led_item_q.size() == 0 && in_launch_cnt == in_acc_cnt &&
             spi_exp_q.size() == 0)) begin
      @(negedge clk);
    end
    repeat (8) @(negedge clk);
  endtask

  task automatic write_all(input logic [7:0] bpc, input logic [7:0] one,
                           input logic [7:0] zero, input logic [7:0] gap);
    write_reg(REG_BITS_PER_CODE, bpc);
    write_reg(REG_PATTERN_ONE, one);
    write_reg(REG_PATTERN_ZERO, zero);
    write_reg(REG_GAP_BYTES, gap);
  endtask

  initial begin
    logic [7:0] bpc;
    logic [7:0] gap;
    logic [7:0] color;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // reset settings
    queue_item(ACT_GAP, 8'h00, 1'b0);
    queue_item(ACT_DATA, 8'h00, 1'b0);
    queue_item(ACT_DATA, 8'hFF, 1'b0);
    queue_item(ACT_DATA, 8'h80, 1'b0);
    queue_item(ACT_DATA, 8'h01, 1'b0);
    queue_item(ACT_DATA, 8'hA5, 1'b0);
    wait_drained();

    // widest code, longest legal gap
    write_all(8'h08, 8'hFF, 8'h00, 8'd64);
    queue_item(ACT_GAP, 8'hFF, 1'b0);
    queue_item(ACT_DATA, 8'h00, 1'b0);
    queue_item(ACT_DATA, 8'hFF, 1'b0);
    queue_item(ACT_DATA, 8'h96, 1'b0);
    wait_drained();

    // one-bit code, wide patterns masked, empty gap
    write_all(8'hF1, 8'hFF, 8'hFE, 8'h80);
    queue_item(ACT_GAP, 8'h00, 1'b0);
    queue_item(ACT_DATA, 8'hFF, 1'b0);
    queue_item(ACT_DATA, 8'h00, 1'b0);
    queue_item(ACT_DATA, 8'h3C, 1'b0);
    wait_drained();

    // code width zero, gap above cap
    write_all(8'h00, 8'hAA, 8'h55, 8'hFF);
    queue_item(ACT_GAP, 8'h00, 1'b0);
    queue_item(ACT_DATA, 8'hC3, 1'b0);
    wait_drained();

    // code width above eight, gap just over cap
    write_all(8'h0F, 8'h5A, 8'hC3, 8'd65);
    queue_item(ACT_GAP, 8'h00, 1'b0);
    queue_item(ACT_DATA, 8'h81, 1'b0);
    queue_item(ACT_DATA, 8'h7E, 1'b0);
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      case ($urandom_range(0, 5))
        0: bpc = 8'd0;
        1: bpc = 8'd8;
        2: bpc = 8'd1;
        3: bpc = 8'($urandom_range(9, 15));
        default: bpc = 8'($urandom_range(1, 8));
      endcase
      bpc[7:4] = 4'($urandom_range(0, 15));
      case ($urandom_range(0, 7))
        0: gap = 8'd0;
        1: gap = 8'd64;
        2: gap = 8'($urandom_range(65, 255));
        default: gap = 8'($urandom_range(1, 6));
      endcase
      write_all(bpc, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), gap);
      in_burst = ($urandom_range(0, 3) == 0);
      out_burst = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < 24; i++) begin
        case ($urandom_range(0, 7))
          0: color = 8'h00;
          1: color = 8'hFF;
          default: color = 8'($urandom_range(0, 255));
        endcase
        queue_item(($urandom_range(0, 9) == 0) ? ACT_GAP : ACT_DATA, color,
                   (ph == 0 && i == 5) || ($urandom_range(0, 15) == 0));
      end
      wait_drained();
    end

    repeat (80) @(negedge clk);
    if (err_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ filelist.f @@
design/lbspi_pkg.sv
design/lbspi_front.sv
design/lbspi_fifo.sv
design/lbspi_back.sv
design/led_bit_to_spi_pattern_encoder.sv
tb/sv/led_bit_to_spi_pattern_encoder_tb.sv
